// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form with explicit clock and active-low reset
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// default form on clk_i / rst_ni
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// types and constants of the chunked response deframer
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int unsigned CapW        = 31;
  localparam int unsigned LengthBitsDef = 31;
  localparam logic [15:0] OpcodeRead  = 16'd97;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic            data_valid;
    logic [7:0]      data_byte;
    logic [CapW-1:0] data_offset;
    logic            done_res;
    logic            status;
    logic [CapW-1:0] copied_count;
  } out_item_t;

endpackage

// File: rtl/core/chunked_response_deframer_core.sv
// ----------------------------------------------------------------------------
// chunked_response_deframer_core
// byte-wide parser of a chunked large-object read response
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | in_valid / in_stall  | in_item_t (kind, rx_byte)
// out     | output    | out_valid / out_stall| out_item_t (one per request)
// cfg     | input     | cfg_valid / cfg_ready| capacity
//
// one request per cycle unless out_stall holds the result register; input register, then result register
// the parser state updates as a request moves into the result register
// out_stall holds the result register and backs up into in_stall in the same cycle
// reset returns the parser to idle with zero counts and zero capacity
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chunked_response_deframer_core import crd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i
);

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhHeader  = 3'd1;
  localparam logic [2:0] PhLenHi   = 3'd2;
  localparam logic [2:0] PhLenLo   = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhPad     = 3'd5;

  localparam int unsigned LB = LENGTH_BITS;

  // pipeline control
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;
  logic      out_free;
  logic      adv;

  // parser state
  logic [LB-1:0] cap_q;
  logic [2:0]    phase_q, phase_d;
  logic [2:0]    hidx_q, hidx_d;
  logic [15:0]   opcode_q, opcode_d;
  logic [31:0]   size_q, size_d;
  logic [LB-1:0] expected_q, expected_d;
  logic [31:0]   streamed_q, streamed_d;
  logic [LB-1:0] copied_q, copied_d;
  logic [7:0]    len_hi_q, len_hi_d;
  logic [15:0]   chunk_len_q, chunk_len_d;
  logic [15:0]   chunk_left_q, chunk_left_d;

  logic [31:0] size_new;
  logic [31:0] cap_ext;
  logic [31:0] stream_sum;
  logic        stream_end;
  logic [15:0] len_new;
  logic [15:0] left_new;
  logic [7:0]  b;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign adv         = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  assign b          = in_item_q.rx_byte;
  assign size_new   = {size_q[23:0], b};
  assign cap_ext    = 32'(cap_q);
  assign stream_sum = streamed_q + 32'(chunk_len_q);
  assign stream_end = stream_sum >= 32'(expected_q);
  assign len_new    = {len_hi_q, b};
  assign left_new   = chunk_left_q - 16'd1;

  always_comb begin
    phase_d      = phase_q;
    hidx_d       = hidx_q;
    opcode_d     = opcode_q;
    size_d       = size_q;
    expected_d   = expected_q;
    streamed_d   = streamed_q;
    copied_d     = copied_q;
    len_hi_d     = len_hi_q;
    chunk_len_d  = chunk_len_q;
    chunk_left_d = chunk_left_q;
    out_item_d   = '0;

    if (in_item_q.kind) begin
      hidx_d       = '0;
      opcode_d     = '0;
      size_d       = '0;
      expected_d   = '0;
      streamed_d   = '0;
      copied_d     = '0;
      len_hi_d     = '0;
      chunk_len_d  = '0;
      chunk_left_d = '0;
      if (cap_q == '0) begin
        phase_d             = PhIdle;
        out_item_d.done_res = 1'b1;
      end else begin
        phase_d = PhHeader;
      end
    end else begin
      unique case (phase_q)
        PhHeader: begin
          if (hidx_q < 3'd2) begin
            opcode_d = {opcode_q[7:0], b};
          end else if (hidx_q >= 3'd4) begin
            size_d = size_new;
          end
          if (hidx_q == 3'd7) begin
            hidx_d = '0;
            if (opcode_q != OpcodeRead) begin
              phase_d             = PhIdle;
              out_item_d.done_res = 1'b1;
              out_item_d.status   = 1'b1;
            end else if (size_new == '0 || size_new[31]) begin
              phase_d             = PhIdle;
              out_item_d.done_res = 1'b1;
            end else begin
              // size is taken only when below capacity, else the capacity, so it fits the length width
              expected_d = (size_new < cap_ext) ? size_new[LB-1:0] : cap_q;
              phase_d    = PhLenHi;
            end
          end else begin
            hidx_d = hidx_q + 3'd1;
          end
        end
        PhLenHi: begin
          len_hi_d = b;
          phase_d  = PhLenLo;
        end
        PhLenLo: begin
          chunk_len_d = len_new;
          if (len_new == '0) begin
            phase_d             = PhIdle;
            out_item_d.done_res = 1'b1;
          end else begin
            chunk_left_d = len_new;
            phase_d      = PhPayload;
          end
        end
        PhPayload: begin
          if (copied_q < cap_q) begin
            out_item_d.data_valid  = 1'b1;
            out_item_d.data_byte   = b;
            out_item_d.data_offset = CapW'(copied_q);
            copied_d               = copied_q + 1'b1;
          end
          chunk_left_d = left_new;
          if (left_new == '0) begin
            if (chunk_len_q[0]) begin
              phase_d = PhPad;
            end else begin
              streamed_d = stream_sum;
              if (stream_end) begin
                phase_d             = PhIdle;
                out_item_d.done_res = 1'b1;
              end else begin
                phase_d = PhLenHi;
              end
            end
          end
        end
        PhPad: begin
          streamed_d = stream_sum;
          if (stream_end) begin
            phase_d             = PhIdle;
            out_item_d.done_res = 1'b1;
          end else begin
            phase_d = PhLenHi;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
    out_item_d.copied_count = CapW'(copied_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (adv) begin
      out_item_q <= out_item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= '0;
      phase_q      <= PhIdle;
      hidx_q       <= '0;
      opcode_q     <= '0;
      size_q       <= '0;
      expected_q   <= '0;
      streamed_q   <= '0;
      copied_q     <= '0;
      len_hi_q     <= '0;
      chunk_len_q  <= '0;
      chunk_left_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i[LB-1:0];
      end
      if (adv) begin
        phase_q      <= phase_d;
        hidx_q       <= hidx_d;
        opcode_q     <= opcode_d;
        size_q       <= size_d;
        expected_q   <= expected_d;
        streamed_q   <= streamed_d;
        copied_q     <= copied_d;
        len_hi_q     <= len_hi_d;
        chunk_len_q  <= chunk_len_d;
        chunk_left_q <= chunk_left_d;
      end
    end
  end

  // a stored byte always bumps the count by one
  `ASSERT_DEF(a_offset_count, out_valid_o && out_item_o.data_valid |-> out_item_o.data_offset + 31'd1 == out_item_o.copied_count, "stored byte offset does not match count")
  // a bad opcode ends the response with nothing stored
  `ASSERT_DEF(a_status_done, out_valid_o && out_item_o.status |-> out_item_o.done_res && out_item_o.copied_count == '0 && !out_item_o.data_valid, "error status without clean completion")
  // payload phase never sits on an exhausted chunk
  `ASSERT_DEF(a_left_nonzero, phase_q == PhPayload |-> chunk_left_q != '0, "payload phase with no bytes left in chunk")

endmodule

// File: dv/chunked_response_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_response_deframer_core_tb
// self-checking bench for the chunked read response deframer: drives framed
// responses, stray bytes and aborted responses with bursty input and a
// stalling receiver, and checks every result against a cycle-free predictor
// ----------------------------------------------------------------------------
module chunked_response_deframer_core_tb;
  import crd_pkg::*;

  localparam logic            KIND_BYTE  = 1'b0;
  localparam logic            KIND_START = 1'b1;
  localparam logic [CapW-1:0] CapMask    = CapW'((64'd1 << LengthBitsDef) - 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_PAD
  } parse_phase_e;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_e;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  in_item_t        in_item_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_item_t       out_item_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CapW-1:0] cfg_data_i  = '0;

  // predictor state
  parse_phase_e    rsp_phase  = PH_IDLE;
  logic [2:0]      hdr_idx    = '0;
  logic [15:0]     opcode_acc = '0;
  logic [31:0]     size_acc   = '0;
  logic [CapW-1:0] expect_len = '0;
  logic [31:0]     stream_len = '0;
  logic [CapW-1:0] copied_len = '0;
  logic [7:0]      len_hi     = '0;
  logic [15:0]     chunk_len  = '0;
  logic [15:0]     chunk_rem  = '0;
  logic [CapW-1:0] capacity_q = '0;

  out_item_t       pending_results[$];
  out_item_t       golden;
  int              err_count  = 0;

  // input pacing and receiver stall control
  int              burst_left = 0;
  int              burst_max  = 4;
  int              gap_max    = 2;
  bit              need_gap   = 1'b1;
  stall_mode_e     stall_mode = STALL_NONE;
  int unsigned     stall_tick = 0;

  chunked_response_deframer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_RANDOM:  out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_PATTERN: out_stall_i <= ((stall_tick % 7) < 3);
      default:       out_stall_i <= 1'b0;
    endcase
  end

  // a chunk is fully consumed: add it to the stream and stop once the expected
  // length is covered
  function automatic bit close_chunk();
    stream_len += 32'(chunk_len);
    if (stream_len >= {1'b0, expect_len}) begin
      rsp_phase = PH_IDLE;
      return 1'b1;
    end
    rsp_phase = PH_LEN_HI;
    return 1'b0;
  endfunction

  function automatic out_item_t deframe_step(in_item_t req);
    out_item_t res;
    res = '0;
    if (req.kind == KIND_START) begin
      hdr_idx    = '0;
      opcode_acc = '0;
      size_acc   = '0;
      expect_len = '0;
      stream_len = '0;
      copied_len = '0;
      len_hi     = '0;
      chunk_len  = '0;
      chunk_rem  = '0;
      if (capacity_q == '0) begin
        rsp_phase    = PH_IDLE;
        res.done_res = 1'b1;
      end else begin
        rsp_phase = PH_HEADER;
      end
    end else begin
      case (rsp_phase)
        PH_HEADER: begin
          if (hdr_idx < 2) opcode_acc = {opcode_acc[7:0], req.rx_byte};
          else if (hdr_idx >= 4) size_acc = {size_acc[23:0], req.rx_byte};
          if (hdr_idx == 3'd7) begin
            hdr_idx = '0;
            if (opcode_acc != OpcodeRead) begin
              rsp_phase    = PH_IDLE;
              res.done_res = 1'b1;
              res.status   = 1'b1;
            end else if (size_acc == '0 || size_acc[31]) begin
              rsp_phase    = PH_IDLE;
              res.done_res = 1'b1;
            end else begin
              expect_len = (size_acc < {1'b0, capacity_q}) ? size_acc[CapW-1:0] : capacity_q;
              rsp_phase  = PH_LEN_HI;
            end
          end else begin
            hdr_idx = hdr_idx + 3'd1;
          end
        end
        PH_LEN_HI: begin
          len_hi    = req.rx_byte;
          rsp_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          chunk_len = {len_hi, req.rx_byte};
          if (chunk_len == '0) begin
            rsp_phase    = PH_IDLE;
            res.done_res = 1'b1;
          end else begin
            chunk_rem = chunk_len;
            rsp_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // bytes past the buffer end are consumed but not stored
          if (copied_len < capacity_q) begin
            res.data_valid  = 1'b1;
            res.data_byte   = req.rx_byte;
            res.data_offset = copied_len;
            copied_len      = copied_len + 1'b1;
          end
          chunk_rem = chunk_rem - 16'd1;
          if (chunk_rem == '0) begin
            if (chunk_len[0]) rsp_phase = PH_PAD;
            else if (close_chunk()) res.done_res = 1'b1;
          end
        end
        PH_PAD: begin
          if (close_chunk()) res.done_res = 1'b1;
        end
        default: rsp_phase = PH_IDLE;
      endcase
    end
    res.copied_count = copied_len;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    err_count++;
    if (err_count <= 40)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_item_o.copied_count), 0);
      end else begin
        golden = pending_results.pop_front();
        check_field("data_valid", 32'(out_item_o.data_valid), 32'(golden.data_valid));
        check_field("data_byte", 32'(out_item_o.data_byte), 32'(golden.data_byte));
        check_field("data_offset", 32'(out_item_o.data_offset), 32'(golden.data_offset));
        check_field("done_res", 32'(out_item_o.done_res), 32'(golden.done_res));
        check_field("status", 32'(out_item_o.status), 32'(golden.status));
        check_field("copied_count", 32'(out_item_o.copied_count),
                    32'(golden.copied_count));
      end
    end
  end

  task automatic send_request(input logic kind, input logic [7:0] value);
    in_item_t req;
    req.kind    = kind;
    req.rx_byte = value;
    if (need_gap) begin
      repeat ((gap_max == 0) ? 1 : $urandom_range(1, gap_max)) @(posedge clk_i);
      need_gap = 1'b0;
    end
    if (burst_left == 0) burst_left = $urandom_range(1, burst_max);
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(deframe_step(req));
    burst_left--;
    // end of a burst: drop valid now, the gap is taken on the next request
    if (burst_left == 0 && gap_max != 0) begin
      in_valid_i <= 1'b0;
      need_gap = 1'b1;
    end
  endtask

  task automatic send_bytes(input logic [63:0] seq, input int count);
    for (int i = 0; i < count; i++) send_request(KIND_BYTE, seq[63 - 8*i -: 8]);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    need_gap   = 1'b1;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    capacity_q = value & CapMask;
  endtask

  // reset capacity is zero: stray bytes are ignored, a start completes at once
  task automatic test_idle_and_empty_buffer();
    stall_mode = STALL_PATTERN;
    send_request(KIND_BYTE, 8'hFF);
    send_request(KIND_START, 8'h00);
    send_request(KIND_BYTE, 8'h00);
  endtask

  // maximal size into a 3 byte buffer, cut short by a new start that then
  // carries a wrong opcode
  task automatic test_overflow_and_restart();
    drain_results();
    write_capacity(CapW'(3));
    send_request(KIND_START, 8'hFF);
    send_bytes(64'h0061_FF00_7FFF_FFFF, 8);
    send_bytes(64'h0005_AA55_FF00_0000, 6);
    send_request(KIND_START, 8'h00);
    send_bytes(64'h0062_0000_0000_0001, 8);
  endtask

  task automatic test_random_responses(input logic [CapW-1:0] cap, input int n_items,
                                       input stall_mode_e smode, input int bmax,
                                       input int gmax);
    int          sent;
    int          budget;
    int          used;
    int          hsent;
    int          pick;
    int          chunk_max;
    logic [15:0] opc;
    logic [31:0] sz;
    logic [63:0] hdr_bytes;
    logic [15:0] next_len;
    logic [7:0]  value;
    drain_results();
    write_capacity(cap);
    stall_mode = smode;
    burst_max  = bmax;
    gap_max    = gmax;
    sent       = 0;
    next_len   = '0;
    while (sent < n_items) begin
      // stray bytes between responses, or tail bytes of a cut response
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_request(KIND_BYTE, 8'($urandom));
          sent++;
        end
      end
      pick = $urandom_range(0, 99);
      opc  = OpcodeRead;
      if (pick < 8) begin
        opc = 16'($urandom);
        if (opc == OpcodeRead) opc = opc ^ 16'h0100;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) sz = '0;
      else if (pick < 12) sz = {1'b1, 31'($urandom)};
      else if (pick < 20) sz = {1'b0, 31'($urandom)};
      else sz = 32'($urandom_range(1, 60));
      hdr_bytes = {opc, 16'($urandom), sz};
      budget    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 14) : 400;
      chunk_max = $urandom_range(1, 16);
      send_request(KIND_START, 8'($urandom));
      sent++;
      used  = 0;
      hsent = 0;
      while (used < budget && (hsent < 8 || rsp_phase != PH_IDLE)) begin
        if (hsent < 8) begin
          value = hdr_bytes[63 - 8*hsent -: 8];
          hsent++;
        end else begin
          case (rsp_phase)
            PH_LEN_HI: begin
              pick = $urandom_range(0, 99);
              if (pick < 6) next_len = '0;
              else if (pick < 10) next_len = 16'($urandom);
              else next_len = 16'($urandom_range(1, chunk_max));
              value = next_len[15:8];
            end
            PH_LEN_LO: value = next_len[7:0];
            default:   value = 8'($urandom);
          endcase
        end
        send_request(KIND_BYTE, value);
        used++;
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_and_empty_buffer();
    test_overflow_and_restart();
    test_random_responses(CapW'(1), 250, STALL_RANDOM, 8, 4);
    test_random_responses(CapW'($urandom_range(2, 40)), 450, STALL_PATTERN, 20, 6);
    test_random_responses({CapW{1'b1}}, 400, STALL_NONE, 1000, 0);
    test_random_responses(CapW'($urandom), 350, STALL_RANDOM, 4, 3);
    test_random_responses('0, 50, STALL_RANDOM, 6, 2);
    drain_results();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
